FILE: design/brf_pkg.sv
// Package for the banked register file: mode codes, configuration addresses and
// the decode helper that maps a processor mode to its R13/R14 bank.
// Used by banked_register_file; depends on nothing else.
package brf_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned MODE_W   = 5;
    localparam int unsigned OFFS_W   = 4;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned LOW_N    = 8;
    localparam int unsigned HIGH_N   = 5;
    localparam int unsigned SPLR_N   = 12;
    localparam int unsigned BANK_W   = 3;
    localparam int unsigned SPLR_W   = 4;

    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

    localparam logic [IDX_W-1:0] REG_R8  = 4'd8;
    localparam logic [IDX_W-1:0] REG_R12 = 4'd12;
    localparam logic [IDX_W-1:0] REG_R13 = 4'd13;
    localparam logic [IDX_W-1:0] REG_R14 = 4'd14;
    localparam logic [IDX_W-1:0] REG_PC  = 4'd15;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_PC_OFFSET = 3'd0;
    localparam logic [OFFS_W-1:0]  PC_OFFSET_RESET = 4'd8;

    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } splr_bank_t;

    function automatic splr_bank_t splr_bank(input logic [MODE_W-1:0] mode);
        splr_bank_t b;
        b.valid = 1'b1;
        case (mode)
            MODE_USR, MODE_SYS: b.bank = 3'd0;
            MODE_FIQ:           b.bank = 3'd1;
            MODE_IRQ:           b.bank = 3'd2;
            MODE_SVC:           b.bank = 3'd3;
            MODE_ABT:           b.bank = 3'd4;
            MODE_UND:           b.bank = 3'd5;
            default:
            begin
                b.valid = 1'b0;
                b.bank  = 3'd0;
            end
        endcase
        return b;
    endfunction

endpackage

FILE: design/banked_register_file.sv
// Banked 32-bit ARM-style register file: FIQ-banked R8-R12, per-mode R13/R14.
// Depends on brf_pkg for mode codes, addresses and the bank decode.
//
// One access is taken per clock whenever start is high; busy is always low.
// Each item gives exactly one result, shown on read_data and mode_error with
// done high for one cycle, after passing the input register and then the bank
// select into the result register. The receiver cannot stall the result. A
// write updates the register file at the same edge that loads its result, so a
// following read sees it. The PC read offset is written through the APB port
// at address 0; the user must do so only while idle. The block does not check.
module banked_register_file
    import brf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [IDX_W-1:0]     reg_index,
    input  logic [MODE_W-1:0]    cpu_mode,
    input  logic [DATA_W-1:0]    write_value,
    output logic                 done,
    output logic [DATA_W-1:0]    read_data,
    output logic                 mode_error,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic               item_valid_reg;
    logic               kind_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [DATA_W-1:0]  wval_reg;

    logic [DATA_W-1:0]  low_reg  [LOW_N];
    logic [DATA_W-1:0]  user_reg [HIGH_N];
    logic [DATA_W-1:0]  fiq_reg  [HIGH_N];
    logic [DATA_W-1:0]  splr_reg [SPLR_N];
    logic [DATA_W-1:0]  pc_reg;
    logic [OFFS_W-1:0]  pc_offset_reg;

    logic               done_reg;
    logic [DATA_W-1:0]  read_data_reg;
    logic               mode_error_reg;
    logic [DATA_W-1:0]  read_data_next;
    logic               mode_error_next;

    logic               is_low;
    logic               is_high;
    logic               is_pc;
    logic               is_splr;
    logic               is_fiq;
    logic [2:0]         high_sel;
    logic [SPLR_W-1:0]  splr_sel;
    splr_bank_t         bank;
    logic [DATA_W-1:0]  slot_value;
    logic               do_write;
    logic               cfg_write;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PC_OFFSET) ? {{(32-OFFS_W){1'b0}}, pc_offset_reg} : 32'd0;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_PC_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg  <= kind;
            index_reg <= reg_index;
            mode_reg  <= cpu_mode;
            wval_reg  <= write_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_offset_reg <= PC_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            pc_offset_reg <= pwdata[OFFS_W-1:0];
        end
    end

    always_comb
    begin
        is_low   = !index_reg[3];
        is_high  = (index_reg >= REG_R8) && (index_reg <= REG_R12);
        is_pc    = (index_reg == REG_PC);
        is_splr  = !is_low && !is_high && !is_pc;
        is_fiq   = (mode_reg == MODE_FIQ);
        high_sel = 3'(index_reg - REG_R8);
        bank     = splr_bank(mode_reg);
        splr_sel = {bank.bank, ~index_reg[0]};

        slot_value = pc_reg;
        if (is_low)
        begin
            slot_value = low_reg[index_reg[2:0]];
        end
        else if (is_high)
        begin
            slot_value = is_fiq ? fiq_reg[high_sel] : user_reg[high_sel];
        end
        else if (is_splr)
        begin
            slot_value = splr_reg[splr_sel];
        end

        mode_error_next = is_splr && !bank.valid;
        do_write        = item_valid_reg && (kind_reg == KIND_WRITE) && !mode_error_next;

        read_data_next = '0;
        if (kind_reg == KIND_READ && !mode_error_next)
        begin
            read_data_next = is_pc ? slot_value + {{(DATA_W-OFFS_W){1'b0}}, pc_offset_reg}
                                   : slot_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOW_N; i++)
            begin
                low_reg[i] <= '0;
            end
            for (int i = 0; i < HIGH_N; i++)
            begin
                user_reg[i] <= '0;
                fiq_reg[i]  <= '0;
            end
            for (int i = 0; i < SPLR_N; i++)
            begin
                splr_reg[i] <= '0;
            end
            pc_reg <= '0;
        end
        else if (do_write)
        begin
            if (is_low)
            begin
                low_reg[index_reg[2:0]] <= wval_reg;
            end
            else if (is_high && is_fiq)
            begin
                fiq_reg[high_sel] <= wval_reg;
            end
            else if (is_high)
            begin
                user_reg[high_sel] <= wval_reg;
            end
            else if (is_pc)
            begin
                pc_reg <= wval_reg;
            end
            else
            begin
                splr_reg[splr_sel] <= wval_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            read_data_reg  <= read_data_next;
            mode_error_reg <= mode_error_next;
        end
    end

    assign done       = done_reg;
    assign read_data  = read_data_reg;
    assign mode_error = mode_error_reg;

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("An accepted item did not produce a result two cycles later.");

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_error) |-> (read_data == '0))
        else $error("A banking error returned nonzero read data.");

    a_error_only_for_sp_lr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_error) |-> ($past(index_reg) == REG_R13 || $past(index_reg) == REG_R14))
        else $error("A banking error was flagged for a register outside R13 and R14.");

endmodule
